FILE: src/rrd_pkg.sv
`default_nettype none

package rrd_pkg;

  // default capacity of the process table
  localparam int unsigned MaxProcsDef = 16;

  localparam logic [15:0] QuantumRst = 16'd4;
  localparam logic [6:0]  NoneId     = 7'h7F;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_SLICE    = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_ALL_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAB_RD,
    ST_EXEC,
    ST_COMPL
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] arrive_tick;
    logic [15:0] work_ticks;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  process_id;
    logic [31:0] start_tick;
    logic [31:0] end_tick;
    logic        extends_previous;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        last_of_run;
  } res_t;

  // one process table entry
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } proc_t;

endpackage

`default_nettype wire

FILE: src/round_robin_dispatcher.sv
`default_nettype none

// Round-robin dispatcher. Load (operation 0) and clear (operation 2) requests
// are handled in the idle state. A dispatch request (operation 1) walks the
// process table once to admit arrivals, reads the ready queue head and its
// table entry, runs it, then walks the table again; with nothing ready it
// ends after the first walk with an idle slice. The table walk reads one
// entry per cycle through the single read port. A dispatch after all
// processes have finished answers done from the idle state. Results appear
// one at a time on res_o with res_valid_o high for one cycle only; the
// receiver has no way to stall them and must take each as it comes. A
// finishing slice is followed in the next cycle by its completion record.
module round_robin_dispatcher #(
  parameter int unsigned MAX_PROCS = rrd_pkg::MaxProcsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  rrd_pkg::req_t      req_i,
  output logic               busy,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  output logic               res_valid_o,
  output rrd_pkg::res_t      res_o
);
  import rrd_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PROCS);
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_PROCS - 1);
  localparam logic [CntW-1:0] Full    = CntW'(MAX_PROCS);

  state_e            state_q, state_d;
  logic [15:0]       quantum_q;
  logic [CntW-1:0]   pcount_q, pcount_d;
  logic [CntW-1:0]   fin_q, fin_d;
  logic [CntW-1:0]   fcount_q, fcount_d;
  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [31:0]       tick_q, tick_d;
  logic [6:0]        prev_q, prev_d;
  logic              started_q, started_d;
  logic [MAX_PROCS-1:0] queued_q, queued_d;
  logic              phase_q, phase_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              chk_v_q, chk_v_d;
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic [IdxW-1:0]   cur_idx_q, cur_idx_d;
  proc_t             cur_q, cur_d;
  logic [31:0]       sstart_q, sstart_d;
  logic              ext_q, ext_d;
  logic [31:0]       tat_q, tat_d;
  logic              res_valid_d;
  res_t              res_q, res_d;

  logic [IdxW-1:0]   fifo_mem_q [MAX_PROCS];
  logic [IdxW-1:0]   fifo_rdata_q;
  logic              fifo_we;
  logic [IdxW-1:0]   fifo_wdata;

  logic              tab_we;
  logic [IdxW-1:0]   tab_waddr, tab_raddr;
  proc_t             tab_wdata, tab_rdata;

  logic              accept;
  logic [15:0]       q_eff, run;
  logic [6:0]        cur_id;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign q_eff  = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
  assign run    = (tab_rdata.remaining < q_eff) ? tab_rdata.remaining : q_eff;
  assign cur_id = 7'(cur_idx_q) + 7'd1;

  rrd_table #(
    .MAX_PROCS(MAX_PROCS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_waddr),
    .wdata_i(tab_wdata),
    .raddr_i(tab_raddr),
    .rdata_o(tab_rdata)
  );

  // ready queue storage, head read every cycle
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem_q[tail_q] <= fifo_wdata;
    end
    fifo_rdata_q <= fifo_mem_q[head_q];
  end

  // quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumRst;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pcount_q    <= '0;
      fin_q       <= '0;
      fcount_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      tick_q      <= '0;
      prev_q      <= NoneId;
      started_q   <= 1'b0;
      queued_q    <= '0;
      phase_q     <= 1'b0;
      scan_q      <= '0;
      chk_v_q     <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcount_q    <= pcount_d;
      fin_q       <= fin_d;
      fcount_q    <= fcount_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      tick_q      <= tick_d;
      prev_q      <= prev_d;
      started_q   <= started_d;
      queued_q    <= queued_d;
      phase_q     <= phase_d;
      scan_q      <= scan_d;
      chk_v_q     <= chk_v_d;
      res_valid_o <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    cur_idx_q <= cur_idx_d;
    cur_q     <= cur_d;
    sstart_q  <= sstart_d;
    ext_q     <= ext_d;
    tat_q     <= tat_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    pcount_d    = pcount_q;
    fin_d       = fin_q;
    fcount_d    = fcount_q;
    head_d      = head_q;
    tail_d      = tail_q;
    tick_d      = tick_q;
    prev_d      = prev_q;
    started_d   = started_q;
    queued_d    = queued_q;
    phase_d     = phase_q;
    scan_d      = scan_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    cur_idx_d   = cur_idx_q;
    cur_d       = cur_q;
    sstart_d    = sstart_q;
    ext_d       = ext_q;
    tat_d       = tat_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    fifo_we     = 1'b0;
    fifo_wdata  = cur_idx_q;
    tab_we      = 1'b0;
    tab_waddr   = pcount_q[IdxW-1:0];
    tab_wdata   = '{arrival: req_i.arrive_tick,
                    burst: (req_i.work_ticks == 16'd0) ? 16'd1 : req_i.work_ticks,
                    remaining: (req_i.work_ticks == 16'd0) ? 16'd1 : req_i.work_ticks};
    tab_raddr   = scan_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_LOAD) begin
            if (!started_q && pcount_q < Full) begin
              tab_we                          = 1'b1;
              queued_d[pcount_q[IdxW-1:0]]    = 1'b0;
              pcount_d                        = pcount_q + 1'b1;
            end
          end else if (req_i.operation == OP_CLEAR) begin
            pcount_d  = '0;
            fin_d     = '0;
            fcount_d  = '0;
            head_d    = '0;
            tail_d    = '0;
            tick_d    = '0;
            prev_d    = NoneId;
            started_d = 1'b0;
            queued_d  = '0;
          end else if (req_i.operation == OP_DISPATCH) begin
            started_d = 1'b1;
            if (fin_q >= pcount_q) begin
              res_valid_d = 1'b1;
              res_d       = '0;
              res_d.kind  = KIND_ALL_DONE;
              res_d.last_of_run = 1'b1;
            end else begin
              phase_d = 1'b0;
              scan_d  = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue one table read per cycle, check it the cycle after
        if (scan_q < pcount_q) begin
          chk_v_d   = 1'b1;
          chk_idx_d = scan_q[IdxW-1:0];
          scan_d    = scan_q + 1'b1;
        end
        if (chk_v_q) begin
          if ({16'd0, tab_rdata.arrival} <= tick_q && !queued_q[chk_idx_q] &&
              tab_rdata.remaining != 16'd0) begin
            fifo_we             = 1'b1;
            fifo_wdata          = chk_idx_q;
            tail_d              = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
            fcount_d            = fcount_q + 1'b1;
            queued_d[chk_idx_q] = 1'b1;
          end
        end else if (scan_q == pcount_q) begin
          res_d = '0;
          if (!phase_q) begin
            if (fcount_q == '0) begin
              // nothing ready: one idle tick
              res_valid_d = 1'b1;
              res_d.kind  = KIND_SLICE;
              res_d.start_tick = tick_q;
              res_d.end_tick   = tick_q + 32'd1;
              res_d.extends_previous = (prev_q == 7'd0);
              res_d.last_of_run = 1'b1;
              prev_d  = 7'd0;
              tick_d  = tick_q + 32'd1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_TAB_RD;
            end
          end else begin
            res_valid_d = 1'b1;
            res_d.kind  = KIND_SLICE;
            res_d.process_id = cur_id;
            res_d.start_tick = sstart_q;
            res_d.end_tick   = tick_q;
            res_d.extends_previous = ext_q;
            if (cur_q.remaining != 16'd0) begin
              // preempted: back to the tail after the new arrivals
              fifo_we  = 1'b1;
              tail_d   = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
              fcount_d = fcount_q + 1'b1;
              res_d.last_of_run = 1'b1;
              state_d  = ST_IDLE;
            end else begin
              fin_d   = fin_q + 1'b1;
              tat_d   = tick_q - {16'd0, cur_q.arrival};
              state_d = ST_COMPL;
            end
          end
        end
      end

      ST_TAB_RD: begin
        cur_idx_d = fifo_rdata_q;
        tab_raddr = fifo_rdata_q;
        state_d   = ST_EXEC;
      end

      ST_EXEC: begin
        // run the head for min(remaining, quantum) and write it back
        cur_d           = tab_rdata;
        cur_d.remaining = tab_rdata.remaining - run;
        tab_we          = 1'b1;
        tab_waddr       = cur_idx_q;
        tab_wdata       = cur_d;
        sstart_d        = tick_q;
        ext_d           = (prev_q == cur_id);
        prev_d          = cur_id;
        tick_d          = tick_q + {16'd0, run};
        head_d          = (head_q == LastIdx) ? '0 : head_q + 1'b1;
        fcount_d        = fcount_q - 1'b1;
        phase_d         = 1'b1;
        scan_d          = '0;
        state_d         = ST_SCAN;
      end

      ST_COMPL: begin
        res_valid_d       = 1'b1;
        res_d             = '0;
        res_d.kind        = KIND_COMPLETE;
        res_d.process_id  = cur_id;
        res_d.end_tick    = tick_q;
        res_d.turnaround  = tat_q;
        res_d.waiting     = tat_q - {16'd0, cur_q.burst};
        res_d.last_of_run = 1'b1;
        state_d           = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/rrd_table.sv
`default_nettype none

// Process table: one write port, one read port, registered read data.
module rrd_table #(
  parameter int unsigned MAX_PROCS = rrd_pkg::MaxProcsDef,
  localparam int unsigned IdxW     = $clog2(MAX_PROCS)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IdxW-1:0]   waddr_i,
  input  wire rrd_pkg::proc_t    wdata_i,
  input  wire logic [IdxW-1:0]   raddr_i,
  output rrd_pkg::proc_t         rdata_o
);
  import rrd_pkg::*;

  proc_t mem_q [MAX_PROCS];
  proc_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/rrd_checker.sv
`default_nettype none

module rrd_checker (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input rrd_pkg::req_t req_i,
  input wire logic     busy,
  input wire logic     res_valid_o,
  input rrd_pkg::res_t res_o
);
  import rrd_pkg::*;

  // a slice that is not last is followed by the completion of the same id
  a_compl_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_SLICE && !res_o.last_of_run |=>
      res_valid_o && res_o.kind == KIND_COMPLETE &&
      res_o.process_id == $past(res_o.process_id))
    else $error("completion record missing after finishing slice");

  // a completion record only comes right after its slice
  a_compl_preceded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_COMPLETE |->
      $past(res_valid_o) && $past(res_o.kind) == KIND_SLICE &&
      !$past(res_o.last_of_run))
    else $error("completion record without its slice");

  // done result is a lone, last result with no id
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_ALL_DONE |->
      res_o.last_of_run && res_o.process_id == 7'd0)
    else $error("malformed done result");

  // loads and clears never produce a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation != OP_DISPATCH |=> !res_valid_o)
    else $error("result after load or clear request");

endmodule

bind round_robin_dispatcher rrd_checker u_rrd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .req_i      (req_i),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

`default_nettype wire
